// ===== hdl/grid_shortest_path_first_step_top_assert.svh =====
// Assertion macros shared by the checker of the grid shortest-path block.
// Every property is sampled on the rising edge of clock and is off in reset.
`ifndef GRID_SHORTEST_PATH_FIRST_STEP_TOP_ASSERT_SVH
`define GRID_SHORTEST_PATH_FIRST_STEP_TOP_ASSERT_SVH

// Plain clocked property with a message.
`define GSP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same-cycle implication.
`define GSP_IMPLIES(lbl, ante, cons, msg) \
   `GSP_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define GSP_NEXT(lbl, ante, cons, msg) \
   `GSP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== hdl/gsp_pkg.sv =====
// Shared types and constants of the grid shortest-path block.
// Used by the top level, the search queue and the port checker.
package gsp_pkg;

   // Distance word of one cell; all ones means not reached.
   localparam int DIST_W = 11;
   localparam logic [DIST_W-1:0] DIST_INF = '1;

   // Item kinds on the request channel.
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_STEP        = 2'd0;
   localparam logic [1:0] STATUS_NO_TARGET   = 2'd1;
   localparam logic [1:0] STATUS_UNREACHABLE = 2'd2;
   localparam logic [1:0] STATUS_AT_TARGET   = 2'd3;

   // Neighbor codes, in increasing cell-number order.
   localparam logic [1:0] NB_LEFT  = 2'd0;
   localparam logic [1:0] NB_DOWN  = 2'd1;
   localparam logic [1:0] NB_UP    = 2'd2;
   localparam logic [1:0] NB_RIGHT = 2'd3;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_POP,
      ST_POP_WAIT,
      ST_CELL,
      ST_NB_RD,
      ST_NB_CHK,
      ST_WALK_TEST,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_FINISH
   } state_type;

   // Control of the search queue.
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } queue_ctrl_type;

endpackage

// ===== hdl/gsp_queue.sv =====
// First-in first-out queue of cell coordinates for the breadth-first search.
// One memory with a registered read; depends on gsp_pkg for its control struct.
module gsp_queue #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gsp_pkg::queue_ctrl_type ctrl,
   input  logic [DATA_W-1:0]       push_data,
   output logic [DATA_W-1:0]       pop_data,
   output logic                    empty
);
   import gsp_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [DATA_W-1:0] q_mem [DEPTH];
   logic [AW:0]       head_ff, head_in;
   logic [AW:0]       tail_ff, tail_in;
   logic [DATA_W-1:0] pop_data_ff;

   // Each cell enters at most once per search, so the pointers never wrap.
   assign empty    = (head_ff == tail_ff);
   assign pop_data = pop_data_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (ctrl.clear) begin
         head_in = '0;
         tail_in = '0;
      end else begin
         if (ctrl.push) begin
            tail_in = tail_ff + 1'b1;
         end
         if (ctrl.pop) begin
            head_in = head_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // Storage: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         q_mem[tail_ff[AW-1:0]] <= push_data;
      end
      pop_data_ff <= q_mem[head_ff[AW-1:0]];
   end

endmodule

// ===== hdl/grid_shortest_path_first_step_top.sv =====
// Top level of the grid shortest-path block: cell memory, search control.
// Depends on gsp_pkg and gsp_queue.
//
// Usage: the request channel (req_*) carries one word per item. A write word
// (req_action 0) sets the blocked bit of one cell and gives no result. A
// query word (req_action 1) gives exactly one result word on the rsp_*
// channel: the first cell of a shortest path from source to target and a
// status. Both channels use valid and stall; a word moves at a rising edge
// with valid high and stall low.
// A query with no target, a cell off the grid or source equal to target
// goes straight to the finish state. Otherwise the block sweeps the cell
// memory, runs a breadth-first search that reads the neighbors of each
// reached cell one at a time through the single read port of the cell
// memory, and walks back from the target.
// Requests are stalled while a query runs. A result waits in an output
// register while rsp_stall is high; the next query may run meanwhile but
// does not finish until that register is free.
// After reset the block clears the blocked map with req_stall high.
module grid_shortest_path_first_step_top #(
   parameter int GRID_W = 32,
   parameter int GRID_H = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [4:0] req_cell_x,
   input  logic [4:0] req_cell_y,
   input  logic       req_cell_blocked,
   input  logic [4:0] req_source_x,
   input  logic [4:0] req_source_y,
   input  logic [4:0] req_target_x,
   input  logic [4:0] req_target_y,
   input  logic       req_target_present,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_step_x,
   output logic [4:0] rsp_step_y,
   output logic [1:0] rsp_status
);
   import gsp_pkg::*;

   localparam int NCELLS = GRID_W * GRID_H;
   localparam int CW     = $clog2(NCELLS);
   localparam int XW     = $clog2(GRID_W);
   localparam int YW     = $clog2(GRID_H);

   function automatic logic [CW-1:0] cell_index(logic [XW-1:0] x, logic [YW-1:0] y);
      return CW'(32'(x) * GRID_H + 32'(y));
   endfunction

   // Control and datapath registers.
   state_type         state_ff, state_in;
   logic [CW:0]       idx_ff, idx_in;
   logic [XW-1:0]     src_x_ff, src_x_in, tgt_x_ff, tgt_x_in, cur_x_ff, cur_x_in;
   logic [YW-1:0]     src_y_ff, src_y_in, tgt_y_ff, tgt_y_in, cur_y_ff, cur_y_in;
   logic [DIST_W-1:0] cur_d_ff, cur_d_in;
   logic [1:0]        nb_ff, nb_in;
   logic [4:0]        res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [4:0]        rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   // Cell memory: {blocked, distance} per cell.
   logic [DIST_W:0]   cell_mem [NCELLS];
   logic [DIST_W:0]   mem_rdata_ff;
   logic [CW-1:0]     mem_raddr, mem_waddr;
   logic [DIST_W:0]   mem_wdata;
   logic              mem_we;

   // Queue interface.
   queue_ctrl_type    q_ctrl;
   logic [XW+YW-1:0]  q_push_data, q_pop_data;
   logic              q_empty;

   // Decoded conditions.
   logic              req_accept, rsp_free, sweep_done, init_done;
   logic              wr_in_grid, query_in_grid, query_same;
   logic              nb_valid;
   logic [XW-1:0]     nb_x;
   logic [YW-1:0]     nb_y;
   logic [CW-1:0]     nb_idx, src_idx, tgt_idx, sweep_waddr;
   logic [XW-1:0]     pop_x;
   logic [YW-1:0]     pop_y;
   logic [DIST_W-1:0] rd_dist;
   logic              rd_blk, relax_ok, nb_is_tgt, walk_hit;

   gsp_queue #(
      .DEPTH  (NCELLS),
      .DATA_W (XW + YW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (q_ctrl),
      .push_data (q_push_data),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_step_x = rsp_x_ff;
   assign rsp_step_y = rsp_y_ff;
   assign rsp_status = rsp_status_ff;

   assign sweep_done  = (32'(idx_ff) == NCELLS);
   assign init_done   = (32'(idx_ff) == NCELLS - 1);
   assign sweep_waddr = CW'(idx_ff - 1'b1);
   assign src_idx     = cell_index(src_x_ff, src_y_ff);
   assign tgt_idx     = cell_index(tgt_x_ff, tgt_y_ff);
   assign pop_x       = q_pop_data[XW+YW-1:YW];
   assign pop_y       = q_pop_data[YW-1:0];
   assign rd_dist     = mem_rdata_ff[DIST_W-1:0];
   assign rd_blk      = mem_rdata_ff[DIST_W];

   assign wr_in_grid = (32'(req_cell_x) < GRID_W) && (32'(req_cell_y) < GRID_H);
   assign query_in_grid = (32'(req_source_x) < GRID_W) && (32'(req_source_y) < GRID_H) &&
                          (32'(req_target_x) < GRID_W) && (32'(req_target_y) < GRID_H);
   assign query_same = (req_source_x == req_target_x) && (req_source_y == req_target_y);

   // Neighbor of the current cell selected by nb_ff.
   always_comb begin
      nb_valid = 1'b0;
      nb_x     = cur_x_ff;
      nb_y     = cur_y_ff;
      case (nb_ff)
         NB_LEFT: begin
            nb_valid = (cur_x_ff != '0);
            nb_x     = cur_x_ff - XW'(1);
         end
         NB_DOWN: begin
            nb_valid = (cur_y_ff != '0);
            nb_y     = cur_y_ff - YW'(1);
         end
         NB_UP: begin
            nb_valid = (32'(cur_y_ff) + 32'd1) < GRID_H;
            nb_y     = cur_y_ff + YW'(1);
         end
         default: begin
            nb_valid = (32'(cur_x_ff) + 32'd1) < GRID_W;
            nb_x     = cur_x_ff + XW'(1);
         end
      endcase
   end

   assign nb_idx    = cell_index(nb_x, nb_y);
   assign nb_is_tgt = (nb_idx == tgt_idx);
   // A neighbor is entered once, if open or the target, below saturation.
   assign relax_ok  = (rd_dist == DIST_INF) && (!rd_blk || nb_is_tgt) &&
                      (cur_d_ff != DIST_INF - DIST_W'(1));
   assign walk_hit  = (rd_dist == cur_d_ff - DIST_W'(1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (init_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && req_action == ACTION_QUERY) begin
               if (!req_target_present || !query_in_grid || query_same) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            if (sweep_done) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            state_in = q_empty ? ST_FINISH : ST_POP_WAIT;
         end
         ST_POP_WAIT: state_in = ST_CELL;
         ST_CELL:     state_in = ST_NB_RD;
         ST_NB_RD: begin
            if (nb_valid) begin
               state_in = ST_NB_CHK;
            end else if (nb_ff == NB_RIGHT) begin
               state_in = ST_POP;
            end
         end
         ST_NB_CHK: begin
            if (relax_ok && nb_is_tgt) begin
               state_in = ST_WALK_TEST;
            end else if (nb_ff == NB_RIGHT) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_NB_RD;
            end
         end
         ST_WALK_TEST: begin
            state_in = (cur_d_ff == DIST_W'(1)) ? ST_FINISH : ST_WALK_RD;
         end
         ST_WALK_RD: begin
            if (nb_valid) begin
               state_in = ST_WALK_CHK;
            end else if (nb_ff == NB_RIGHT) begin
               state_in = ST_WALK_TEST;
            end
         end
         ST_WALK_CHK: begin
            if (walk_hit || nb_ff == NB_RIGHT) begin
               state_in = ST_WALK_TEST;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Datapath, memory and queue control.
   always_comb begin
      idx_in        = idx_ff;
      src_x_in      = src_x_ff;
      src_y_in      = src_y_ff;
      tgt_x_in      = tgt_x_ff;
      tgt_y_in      = tgt_y_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      cur_d_in      = cur_d_ff;
      nb_in         = nb_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_status_in = res_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_raddr     = idx_ff[CW-1:0];
      mem_waddr     = idx_ff[CW-1:0];
      mem_wdata     = {1'b0, DIST_INF};
      mem_we        = 1'b0;
      q_ctrl        = '0;
      q_push_data   = {nb_x, nb_y};
      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         ST_IDLE: begin
            idx_in = '0;
            if (req_accept && req_action == ACTION_WRITE && wr_in_grid) begin
               // A write also marks the cell unreached; the next query rewrites it.
               mem_we    = 1'b1;
               mem_waddr = cell_index(XW'(req_cell_x), YW'(req_cell_y));
               mem_wdata = {req_cell_blocked, DIST_INF};
            end
            if (req_accept && req_action == ACTION_QUERY) begin
               src_x_in      = XW'(req_source_x);
               src_y_in      = YW'(req_source_y);
               tgt_x_in      = XW'(req_target_x);
               tgt_y_in      = YW'(req_target_y);
               res_x_in      = 5'd0;
               res_y_in      = 5'd0;
               q_ctrl.clear  = 1'b1;
               if (!req_target_present) begin
                  res_status_in = STATUS_NO_TARGET;
               end else if (!query_in_grid) begin
                  res_status_in = STATUS_UNREACHABLE;
               end else if (query_same) begin
                  res_x_in      = req_source_x;
                  res_y_in      = req_source_y;
                  res_status_in = STATUS_AT_TARGET;
               end
            end
         end
         ST_CLEAR: begin
            // Read ahead one cell and rewrite the previous one, keeping its blocked bit.
            idx_in = idx_ff + 1'b1;
            if (idx_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = sweep_waddr;
               mem_wdata = {rd_blk, (sweep_waddr == src_idx) ? DIST_W'(0) : DIST_INF};
            end
            if (sweep_done) begin
               q_ctrl.push = 1'b1;
               q_push_data = {src_x_ff, src_y_ff};
            end
         end
         ST_POP: begin
            if (q_empty) begin
               res_status_in = STATUS_UNREACHABLE;
            end else begin
               q_ctrl.pop = 1'b1;
            end
         end
         ST_POP_WAIT: begin
            cur_x_in  = pop_x;
            cur_y_in  = pop_y;
            mem_raddr = cell_index(pop_x, pop_y);
         end
         ST_CELL: begin
            cur_d_in = rd_dist;
            nb_in    = NB_LEFT;
         end
         ST_NB_RD: begin
            mem_raddr = nb_idx;
            if (!nb_valid) begin
               nb_in = nb_ff + 2'd1;
            end
         end
         ST_NB_CHK: begin
            nb_in = nb_ff + 2'd1;
            if (relax_ok) begin
               mem_we      = 1'b1;
               mem_waddr   = nb_idx;
               mem_wdata   = {rd_blk, cur_d_ff + DIST_W'(1)};
               q_ctrl.push = 1'b1;
               if (nb_is_tgt) begin
                  cur_x_in = nb_x;
                  cur_y_in = nb_y;
                  cur_d_in = cur_d_ff + DIST_W'(1);
               end
            end
         end
         ST_WALK_TEST: begin
            nb_in = NB_LEFT;
            if (cur_d_ff == DIST_W'(1)) begin
               res_x_in      = 5'(cur_x_ff);
               res_y_in      = 5'(cur_y_ff);
               res_status_in = STATUS_STEP;
            end
         end
         ST_WALK_RD: begin
            mem_raddr = nb_idx;
            if (!nb_valid) begin
               nb_in = nb_ff + 2'd1;
            end
         end
         ST_WALK_CHK: begin
            // The lowest-numbered neighbor one step closer is the predecessor.
            nb_in = nb_ff + 2'd1;
            if (walk_hit) begin
               cur_x_in = nb_x;
               cur_y_in = nb_y;
               cur_d_in = cur_d_ff - DIST_W'(1);
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = res_x_ff;
               rsp_y_in      = res_y_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      src_x_ff      <= src_x_in;
      src_y_ff      <= src_y_in;
      tgt_x_ff      <= tgt_x_in;
      tgt_y_ff      <= tgt_y_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      cur_d_ff      <= cur_d_in;
      nb_ff         <= nb_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_status_ff <= res_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Cell memory: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= cell_mem[mem_raddr];
   end

endmodule

// ===== hdl/gsp_checker.sv =====
// Port checker of the grid shortest-path block, bound to the top level.
// Depends on gsp_pkg and the assertion macro header.
`include "grid_shortest_path_first_step_top_assert.svh"

module gsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_action,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [4:0] rsp_step_x,
   input logic [4:0] rsp_step_y,
   input logic [1:0] rsp_status
);
   import gsp_pkg::*;

   logic       query_word, rsp_word, fail_word;
   logic [1:0] pend_ff, pend_in;

   assign query_word = req_valid && !req_stall && (req_action == ACTION_QUERY);
   assign rsp_word   = rsp_valid && !rsp_stall;
   assign fail_word  = rsp_valid &&
                       (rsp_status == STATUS_NO_TARGET || rsp_status == STATUS_UNREACHABLE);

   // Queries accepted whose result word has not yet moved.
   always_comb begin
      pend_in = pend_ff;
      if (query_word && !rsp_word) begin
         pend_in = pend_ff + 2'd1;
      end else if (!query_word && rsp_word) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `GSP_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled result word dropped")
   `GSP_IMPLIES(a_rsp_has_query, rsp_valid, pend_ff != 2'd0, "result word without a query")
   `GSP_IMPLIES(a_fail_zero, fail_word, rsp_step_x == 5'd0 && rsp_step_y == 5'd0, "bad cell")
   `GSP_IMPLIES(a_init_stall, $past(reset), req_stall, "requests taken during map clear")

endmodule

bind grid_shortest_path_first_step_top gsp_checker u_gsp_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for grid_shortest_path_first_step_top.
// It predicts each query's first step with its own grid search; it depends
// on gsp_pkg and on the block's RTL.
module testbench;
   import gsp_pkg::*;

   localparam int GRID_W       = 32;
   localparam int GRID_H       = 32;
   localparam int CELLS        = GRID_W * GRID_H;
   localparam int FAR_AWAY     = int'(DIST_INF);
   localparam int IDLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES  = 60000;
   localparam int RANDOM_WORDS = 40;

   typedef struct {
      logic       action;
      logic [4:0] cell_x, cell_y;
      logic       cell_blocked;
      logic [4:0] source_x, source_y, target_x, target_y;
      logic       target_present;
   } req_word_type;

   typedef struct {
      logic [4:0] step_x, step_y;
      logic [1:0] status;
   } step_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_action = 1'b0;
   logic [4:0] req_cell_x = '0, req_cell_y = '0;
   logic       req_cell_blocked = 1'b0;
   logic [4:0] req_source_x = '0, req_source_y = '0;
   logic [4:0] req_target_x = '0, req_target_y = '0;
   logic       req_target_present = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [4:0] rsp_step_x, rsp_step_y;
   logic [1:0] rsp_status;

   // Predictor state: our own copy of the blocked map.
   bit            wall_map [CELLS];
   step_word_type pending_steps [$];
   int            error_count = 0;
   int            send_idle_pct = 0;
   int            rsp_stall_pct = 0;
   bit            hold_request = 1'b0;
   int            hold_left = 0;
   int            idle_cycles = 0;

   grid_shortest_path_first_step_top #(.GRID_W(GRID_W), .GRID_H(GRID_H)) dut (.*);

   always #6 clock = ~clock;

   // Runs the search from the source and returns the first step of the path.
   function automatic step_word_type plan_first_step(input req_word_type w);
      int            hop_dist [CELLS];
      int            came_from [CELLS];
      bit            settled [CELLS];
      int            src, dst, best, best_dist, x, y, nb, nd, cur, steps;
      int            nbs [4];
      bit            nb_ok [4];
      step_word_type r;
      r.step_x = '0;
      r.step_y = '0;
      r.status = STATUS_STEP;
      if (!w.target_present) begin
         r.status = STATUS_NO_TARGET;
         return r;
      end
      src = w.source_x * GRID_H + w.source_y;
      dst = w.target_x * GRID_H + w.target_y;
      if (src == dst) begin
         r.step_x = w.source_x;
         r.step_y = w.source_y;
         r.status = STATUS_AT_TARGET;
         return r;
      end
      for (int i = 0; i < CELLS; i++) begin
         hop_dist[i] = FAR_AWAY;
         came_from[i] = 0;
         settled[i] = 1'b0;
      end
      hop_dist[src] = 0;
      while (1) begin
         best = -1;
         best_dist = FAR_AWAY;
         // Lowest cell number wins among equal distances.
         for (int i = 0; i < CELLS; i++) begin
            if (!settled[i] && hop_dist[i] < best_dist) begin
               best_dist = hop_dist[i];
               best = i;
            end
         end
         if (best < 0) break;
         settled[best] = 1'b1;
         x = best / GRID_H;
         y = best % GRID_H;
         nbs[0] = best - GRID_H;  nb_ok[0] = (x > 0);
         nbs[1] = best + GRID_H;  nb_ok[1] = (x + 1 < GRID_W);
         nbs[2] = best - 1;       nb_ok[2] = (y > 0);
         nbs[3] = best + 1;       nb_ok[3] = (y + 1 < GRID_H);
         for (int k = 0; k < 4; k++) begin
            nb = nbs[k];
            // The target cell always counts as open.
            if (nb_ok[k] && !settled[nb] && (!wall_map[nb] || nb == dst)) begin
               nd = (hop_dist[best] + 1 > FAR_AWAY) ? FAR_AWAY : hop_dist[best] + 1;
               if (nd < hop_dist[nb]) begin
                  hop_dist[nb] = nd;
                  came_from[nb] = best;
               end
            end
         end
      end
      if (hop_dist[dst] >= FAR_AWAY) begin
         r.status = STATUS_UNREACHABLE;
         return r;
      end
      // Walk back from the target to the cell next to the source.
      cur = dst;
      steps = 0;
      while (came_from[cur] != src && steps < CELLS) begin
         cur = came_from[cur];
         steps++;
      end
      r.step_x = 5'(cur / GRID_H);
      r.step_y = 5'(cur % GRID_H);
      return r;
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // Offers one word, waits for it to be taken and updates the prediction.
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= w.action;
      req_cell_x         <= w.cell_x;
      req_cell_y         <= w.cell_y;
      req_cell_blocked   <= w.cell_blocked;
      req_source_x       <= w.source_x;
      req_source_y       <= w.source_y;
      req_target_x       <= w.target_x;
      req_target_y       <= w.target_y;
      req_target_present <= w.target_present;
      do @(posedge clock); while (req_stall);
      if (w.action == ACTION_WRITE) begin
         wall_map[w.cell_x * GRID_H + w.cell_y] = w.cell_blocked;
      end else begin
         pending_steps.insert(pending_steps.size(), plan_first_step(w));
      end
   endtask

   function automatic req_word_type noise_word();
      req_word_type w;
      w.action = 1'($urandom_range(1));
      w.cell_x = 5'($urandom);
      w.cell_y = 5'($urandom);
      w.cell_blocked = 1'($urandom_range(1));
      w.source_x = 5'($urandom);
      w.source_y = 5'($urandom);
      w.target_x = 5'($urandom);
      w.target_y = 5'($urandom);
      w.target_present = 1'($urandom_range(1));
      return w;
   endfunction

   task automatic send_write(input int x, input int y, input bit blocked);
      req_word_type w;
      w = noise_word();
      w.action = ACTION_WRITE;
      w.cell_x = 5'(x);
      w.cell_y = 5'(y);
      w.cell_blocked = blocked;
      send_word(w);
   endtask

   task automatic send_query(input int sx, input int sy, input int tx, input int ty,
                             input bit present);
      req_word_type w;
      w = noise_word();
      w.action = ACTION_QUERY;
      w.source_x = 5'(sx);
      w.source_y = 5'(sy);
      w.target_x = 5'(tx);
      w.target_y = 5'(ty);
      w.target_present = present;
      send_word(w);
   endtask

   // Corners, missing target, source on target, boxed-in source and blocked target.
   task automatic test_directed();
      send_query(31, 31, 31, 31, 1'b0);
      send_query(31, 31, 31, 31, 1'b1);
      send_query(0, 0, 0, 0, 1'b1);
      send_query(0, 0, 31, 31, 1'b1);
      send_query(31, 0, 0, 31, 1'b1);
      send_write(0, 1, 1'b1);
      send_write(1, 0, 1'b1);
      send_query(0, 0, 5, 5, 1'b1);
      send_query(0, 0, 0, 1, 1'b1);
      send_write(1, 0, 1'b0);
      send_query(0, 0, 5, 5, 1'b1);
      send_write(31, 31, 1'b1);
      send_query(30, 31, 31, 31, 1'b1);
      send_query(0, 31, 31, 31, 1'b1);
      send_write(31, 31, 1'b0);
      send_write(0, 1, 1'b0);
   endtask

   // Mazes built by random writes, probed by random queries.
   task automatic test_random(input int count);
      req_word_type w;
      for (int i = 0; i < count; i++) begin
         w = noise_word();
         if ($urandom_range(99) < 60) begin
            w.action = ACTION_WRITE;
            w.cell_blocked = ($urandom_range(99) < 35);
         end else begin
            w.action = ACTION_QUERY;
            w.target_present = ($urandom_range(99) < 94);
            if ($urandom_range(99) < 5) begin
               w.target_x = w.source_x;
               w.target_y = w.source_y;
            end
         end
         send_word(w);
      end
   endtask

   // The receiver holds off long enough for the block to back up its input.
   task automatic test_backpressure();
      hold_request = 1'b1;
      send_query(0, 0, 31, 31, 1'b1);
      send_query(31, 31, 0, 0, 1'b1);
      send_query(0, 31, 31, 0, 1'b1);
   endtask

   // Result side stall, with a long hold-off when a test requests one.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Compares each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      step_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_steps.size() == 0) begin
            note_error($sformatf("unexpected result %0d,%0d status %0d",
                                 rsp_step_x, rsp_step_y, rsp_status));
         end else begin
            want = pending_steps.pop_front();
            if (rsp_step_x !== want.step_x || rsp_step_y !== want.step_y ||
                rsp_status !== want.status) begin
               note_error($sformatf("expected %0d,%0d status %0d, got %0d,%0d status %0d",
                                    want.step_x, want.step_y, want.status,
                                    rsp_step_x, rsp_step_y, rsp_status));
            end
         end
      end
   end

   // Ends the run when neither channel moves a word for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 12;
      rsp_stall_pct = 71;
      test_directed();
      test_random(RANDOM_WORDS);
      send_idle_pct = 71;
      rsp_stall_pct = 12;
      test_random(RANDOM_WORDS);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_backpressure();
      test_random(RANDOM_WORDS);
      req_valid <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/gsp_pkg.sv
hdl/gsp_queue.sv
hdl/grid_shortest_path_first_step_top.sv
hdl/gsp_checker.sv
verif/testbench.sv
